### rtl/assert_macros.svh
// assertion macros used by the checker file wdlm_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/wdlm_pkg.sv
// types and constants for the window debounce level monitor
// no dependencies
package wdlm_pkg;

	localparam int SAMPLE_W = 13;
	localparam int COUNT_W  = 8;
	localparam int RAW_W    = 16;
	localparam int IDX_W    = 8;
	localparam int DATA_W   = 16;

	localparam logic [SAMPLE_W-1:0] SAMPLE_CEIL = 13'd4096;
	localparam logic [COUNT_W-1:0]  COUNT_CEIL  = 8'd255;

	typedef enum logic [IDX_W-1:0] {
		REG_FAULT_MAX    = 8'd0,
		REG_FAULT_MIN    = 8'd1,
		REG_OK_MAX       = 8'd2,
		REG_OK_MIN       = 8'd3,
		REG_RISE_LIMIT   = 8'd4,
		REG_FALL_LIMIT   = 8'd5,
		REG_SUPPLY_LEVEL = 8'd6,
		REG_GROUND_LEVEL = 8'd7
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] RST_FAULT_MAX    = 13'd1500;
	localparam logic [SAMPLE_W-1:0] RST_FAULT_MIN    = 13'd1000;
	localparam logic [SAMPLE_W-1:0] RST_OK_MAX       = 13'd3000;
	localparam logic [SAMPLE_W-1:0] RST_OK_MIN       = 13'd2500;
	localparam logic [COUNT_W-1:0]  RST_RISE_LIMIT   = 8'd5;
	localparam logic [COUNT_W-1:0]  RST_FALL_LIMIT   = 8'd5;
	localparam logic [SAMPLE_W-1:0] RST_SUPPLY_LEVEL = 13'd4000;
	localparam logic [SAMPLE_W-1:0] RST_GROUND_LEVEL = 13'd100;

	typedef struct packed {
		logic [SAMPLE_W-1:0] fault_max;
		logic [SAMPLE_W-1:0] fault_min;
		logic [SAMPLE_W-1:0] ok_max;
		logic [SAMPLE_W-1:0] ok_min;
		logic [COUNT_W-1:0]  rise_limit;
		logic [COUNT_W-1:0]  fall_limit;
		logic [SAMPLE_W-1:0] supply_level;
		logic [SAMPLE_W-1:0] ground_level;
	} cfg_t;

endpackage

### rtl/window_debounce_level_monitor.sv
// window comparator with debounce counter and short/invalid level diagnosis
// depends on wdlm_pkg
// an accepted request is registered in the input stage, then its result in the state registers
// throughput: one request per cycle while results are taken, set by the single state update path
// the state registers double as the result register and hold while a result stalls
// asynchronous active-low reset clears the control and state (measured state set), loads register defaults
module window_debounce_level_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wdlm_pkg::RAW_W-1:0]    raw_sample,
	input  logic                          integration_mode,
	input  logic                          acquire_enable,
	input  logic                          diag_inhibit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wdlm_pkg::SAMPLE_W-1:0] clamped_sample,
	output logic                          measured_state,
	output logic                          filtered_state,
	output logic                          short_supply_flag,
	output logic                          short_ground_flag,
	output logic                          invalid_level_flag,
	output logic                          monitor_running,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wdlm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [wdlm_pkg::DATA_W-1:0]   cfg_data
);

	wdlm_pkg::cfg_t cfg_q;

	logic                          vld_s1;
	logic [wdlm_pkg::RAW_W-1:0]    raw_s1;
	logic                          integ_s1;
	logic                          acq_s1;
	logic                          inhibit_s1;

	logic [wdlm_pkg::SAMPLE_W-1:0] sample_q;
	logic                          meas_q;
	logic                          filt_q;
	logic [wdlm_pkg::COUNT_W-1:0]  count_q;
	logic                          supply_q;
	logic                          ground_q;
	logic                          invalid_q;
	logic                          monitor_q;
	logic                          out_vld_q;

	logic                          advance;
	logic                          work;
	logic [wdlm_pkg::SAMPLE_W-1:0] sample_d;
	logic                          in_fault;
	logic                          in_ok;
	logic                          meas_d;
	logic                          filt_d;
	logic [wdlm_pkg::COUNT_W-1:0]  count_inc;
	logic [wdlm_pkg::COUNT_W-1:0]  count_d;
	logic [wdlm_pkg::COUNT_W-1:0]  limit;
	logic                          hi;
	logic                          lo;

	assign cfg_ready = 1'b1;
	assign advance   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign work      = !integ_s1 && acq_s1;

	always_comb begin
		sample_d  = (raw_s1 >= {{(wdlm_pkg::RAW_W-wdlm_pkg::SAMPLE_W){1'b0}},
			wdlm_pkg::SAMPLE_CEIL}) ? wdlm_pkg::SAMPLE_CEIL
			: raw_s1[wdlm_pkg::SAMPLE_W-1:0];
		in_fault  = (sample_d >= cfg_q.fault_min) && (sample_d <= cfg_q.fault_max);
		in_ok     = (sample_d >= cfg_q.ok_min) && (sample_d <= cfg_q.ok_max);
		meas_d    = in_fault ? 1'b0 : (in_ok ? 1'b1 : meas_q);
		limit     = meas_d ? cfg_q.rise_limit : cfg_q.fall_limit;
		count_inc = (count_q == wdlm_pkg::COUNT_CEIL) ? count_q : count_q + 8'd1;
		filt_d    = filt_q;
		count_d   = '0;
		if (meas_d != filt_q) begin
			if (count_inc > limit) begin
				filt_d = meas_d;
			end else begin
				count_d = count_inc;
			end
		end
		hi = sample_d >= cfg_q.supply_level;
		lo = sample_d <= cfg_q.ground_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fault_max    <= wdlm_pkg::RST_FAULT_MAX;
			cfg_q.fault_min    <= wdlm_pkg::RST_FAULT_MIN;
			cfg_q.ok_max       <= wdlm_pkg::RST_OK_MAX;
			cfg_q.ok_min       <= wdlm_pkg::RST_OK_MIN;
			cfg_q.rise_limit   <= wdlm_pkg::RST_RISE_LIMIT;
			cfg_q.fall_limit   <= wdlm_pkg::RST_FALL_LIMIT;
			cfg_q.supply_level <= wdlm_pkg::RST_SUPPLY_LEVEL;
			cfg_q.ground_level <= wdlm_pkg::RST_GROUND_LEVEL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wdlm_pkg::REG_FAULT_MAX:    cfg_q.fault_max    <= cfg_data[12:0];
				wdlm_pkg::REG_FAULT_MIN:    cfg_q.fault_min    <= cfg_data[12:0];
				wdlm_pkg::REG_OK_MAX:       cfg_q.ok_max       <= cfg_data[12:0];
				wdlm_pkg::REG_OK_MIN:       cfg_q.ok_min       <= cfg_data[12:0];
				wdlm_pkg::REG_RISE_LIMIT:   cfg_q.rise_limit   <= cfg_data[7:0];
				wdlm_pkg::REG_FALL_LIMIT:   cfg_q.fall_limit   <= cfg_data[7:0];
				wdlm_pkg::REG_SUPPLY_LEVEL: cfg_q.supply_level <= cfg_data[12:0];
				wdlm_pkg::REG_GROUND_LEVEL: cfg_q.ground_level <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1     <= raw_sample;
			integ_s1   <= integration_mode;
			acq_s1     <= acquire_enable;
			inhibit_s1 <= diag_inhibit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q  <= '0;
			meas_q    <= 1'b1;
			filt_q    <= 1'b0;
			count_q   <= '0;
			supply_q  <= 1'b0;
			ground_q  <= 1'b0;
			invalid_q <= 1'b0;
			monitor_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (advance && work) begin
				sample_q <= sample_d;
				meas_q   <= meas_d;
				filt_q   <= filt_d;
				count_q  <= count_d;
				if (inhibit_s1) begin
					monitor_q <= 1'b0;
				end else begin
					supply_q  <= hi;
					ground_q  <= lo;
					invalid_q <= !(in_fault || in_ok || hi || lo);
					monitor_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid          = out_vld_q;
	assign clamped_sample     = sample_q;
	assign measured_state     = meas_q;
	assign filtered_state     = filt_q;
	assign short_supply_flag  = supply_q;
	assign short_ground_flag  = ground_q;
	assign invalid_level_flag = invalid_q;
	assign monitor_running    = monitor_q;

endmodule

### rtl/wdlm_checker.sv
// port-level checks for the window debounce level monitor, bound to the top level
// depends on wdlm_pkg and assert_macros.svh
`include "assert_macros.svh"

module wdlm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wdlm_pkg::SAMPLE_W-1:0] clamped_sample,
	input logic                          short_supply_flag,
	input logic                          short_ground_flag,
	input logic                          invalid_level_flag
);

	`ASSERT_IMPL(a_clamp_range, clk, arst_n, 1'b1, clamped_sample <= wdlm_pkg::SAMPLE_CEIL)
	`ASSERT_IMPL(a_invalid_excl, clk, arst_n, invalid_level_flag, !short_supply_flag && !short_ground_flag)
	`ASSERT_NEXT(a_ready_on_drain, clk, arst_n, in_valid && !in_ready, out_valid)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(clamped_sample))

endmodule

bind window_debounce_level_monitor wdlm_checker u_wdlm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.clamped_sample     (clamped_sample),
	.short_supply_flag  (short_supply_flag),
	.short_ground_flag  (short_ground_flag),
	.invalid_level_flag (invalid_level_flag)
);

### sim/window_debounce_level_monitor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for window_debounce_level_monitor: windows, debounce, level flags
// depends on wdlm_pkg and the rtl top; tracks expected state itself and checks every result
module window_debounce_level_monitor_tb;

	localparam int LATENCY        = 1;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;
	localparam int NUM_REGS       = int'(wdlm_pkg::REG_GROUND_LEVEL) + 1;
	localparam int IDX_TOP        = 2 ** wdlm_pkg::IDX_W - 1;
	localparam int SAMPLE_TOP     = int'(wdlm_pkg::SAMPLE_CEIL);
	localparam int REG13_TOP      = 2 ** wdlm_pkg::SAMPLE_W - 1;
	localparam int COUNT_TOP      = int'(wdlm_pkg::COUNT_CEIL);
	localparam int RAW_TOP        = 2 ** wdlm_pkg::RAW_W - 1;

	typedef enum int {SET_RANDOM, SET_LOW, SET_HIGH} reg_setting_t;
	typedef enum int {PICK_FAULT, PICK_OK, PICK_EDGE, PICK_SPAN, PICK_WIDE} pick_kind_t;

	typedef struct packed {
		logic [wdlm_pkg::SAMPLE_W-1:0] sample;
		logic                          measured;
		logic                          filtered;
		logic                          supply;
		logic                          ground;
		logic                          invalid;
		logic                          monitor;
	} level_result_t;

	logic                          clk              = 1'b0;
	logic                          arst_n           = 1'b0;
	logic                          in_valid         = 1'b0;
	logic                          in_ready;
	logic [wdlm_pkg::RAW_W-1:0]    raw_sample       = '0;
	logic                          integration_mode = 1'b0;
	logic                          acquire_enable   = 1'b0;
	logic                          diag_inhibit     = 1'b0;
	logic                          out_valid;
	logic                          out_ready        = 1'b0;
	logic [wdlm_pkg::SAMPLE_W-1:0] clamped_sample;
	logic                          measured_state;
	logic                          filtered_state;
	logic                          short_supply_flag;
	logic                          short_ground_flag;
	logic                          invalid_level_flag;
	logic                          monitor_running;
	logic                          cfg_valid        = 1'b0;
	logic                          cfg_ready;
	logic [wdlm_pkg::IDX_W-1:0]    cfg_index        = '0;
	logic [wdlm_pkg::DATA_W-1:0]   cfg_data         = '0;

	wdlm_pkg::cfg_t                cfg_model;
	level_result_t                 trk;
	logic [wdlm_pkg::COUNT_W-1:0]  trk_count;
	level_result_t                 expected_levels[$];
	level_result_t                 got_levels;
	level_result_t                 want_levels;
	int                            fail_count    = 0;
	int                            idle_cycles   = 0;
	int                            send_gap_pct  = 0;
	int                            recv_gap_pct  = 0;
	int                            hold_left     = 0;

	window_debounce_level_monitor uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.raw_sample         (raw_sample),
		.integration_mode   (integration_mode),
		.acquire_enable     (acquire_enable),
		.diag_inhibit       (diag_inhibit),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.clamped_sample     (clamped_sample),
		.measured_state     (measured_state),
		.filtered_state     (filtered_state),
		.short_supply_flag  (short_supply_flag),
		.short_ground_flag  (short_ground_flag),
		.invalid_level_flag (invalid_level_flag),
		.monitor_running    (monitor_running),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic level_result_t predict_tick(input logic [wdlm_pkg::RAW_W-1:0] raw,
			input logic integ, input logic acq, input logic inh);
		logic [wdlm_pkg::SAMPLE_W-1:0] s;
		logic                          in_fault;
		logic                          in_ok;
		logic                          hi;
		logic                          lo;
		logic [wdlm_pkg::COUNT_W-1:0]  limit;
		if (!integ && acq) begin
			s = (raw < wdlm_pkg::SAMPLE_CEIL) ? raw[wdlm_pkg::SAMPLE_W-1:0]
				: wdlm_pkg::SAMPLE_CEIL;
			trk.sample = s;
			in_fault = (s >= cfg_model.fault_min) && (s <= cfg_model.fault_max);
			in_ok = (s >= cfg_model.ok_min) && (s <= cfg_model.ok_max);
			if (in_fault)
				trk.measured = 1'b0;
			else if (in_ok)
				trk.measured = 1'b1;
			if (trk.measured != trk.filtered) begin
				limit = trk.measured ? cfg_model.rise_limit : cfg_model.fall_limit;
				if (trk_count < wdlm_pkg::COUNT_CEIL)
					trk_count = trk_count + 1'b1;
				if (trk_count > limit) begin
					trk.filtered = trk.measured;
					trk_count = '0;
				end
			end else begin
				trk_count = '0;
			end
			if (inh) begin
				trk.monitor = 1'b0;
			end else begin
				hi = s >= cfg_model.supply_level;
				lo = s <= cfg_model.ground_level;
				trk.supply = hi;
				trk.ground = lo;
				trk.invalid = !(in_fault || in_ok || hi || lo);
				trk.monitor = 1'b1;
			end
		end
		return trk;
	endfunction

	function automatic string show_levels(input level_result_t r);
		return $sformatf("sample=%0d meas=%0b filt=%0b sup=%0b gnd=%0b inv=%0b mon=%0b",
			r.sample, r.measured, r.filtered, r.supply, r.ground, r.invalid, r.monitor);
	endfunction

	function automatic logic [wdlm_pkg::DATA_W-1:0] noisy(input int v, input int w);
		logic [wdlm_pkg::DATA_W-1:0] d;
		logic [wdlm_pkg::DATA_W-1:0] mask;
		d = wdlm_pkg::DATA_W'($urandom);
		mask = wdlm_pkg::DATA_W'((1 << w) - 1);
		return (d & ~mask) | (v[wdlm_pkg::DATA_W-1:0] & mask);
	endfunction

	function automatic int pick_between(input int lo, input int hi);
		if (lo > hi || lo > SAMPLE_TOP)
			return $urandom_range(0, SAMPLE_TOP);
		return $urandom_range(lo, (hi > SAMPLE_TOP) ? SAMPLE_TOP : hi);
	endfunction

	function automatic int window_top(input int lo);
		if ($urandom_range(99) < 12)
			return (lo > 0) ? $urandom_range(0, lo - 1) : 0;
		return lo + $urandom_range(0, 900);
	endfunction

	function automatic int debounce_pick();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 7);
		if (r < 90)
			return $urandom_range(8, 40);
		return COUNT_TOP;
	endfunction

	function automatic pick_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return PICK_FAULT;
		if (r < 60)
			return PICK_OK;
		if (r < 75)
			return PICK_EDGE;
		if (r < 87)
			return PICK_SPAN;
		return PICK_WIDE;
	endfunction

	function automatic logic [wdlm_pkg::RAW_W-1:0] pick_sample(input pick_kind_t kind);
		int base;
		int v;
		base = 0;
		case (kind)
			PICK_FAULT: v = pick_between(cfg_model.fault_min, cfg_model.fault_max);
			PICK_OK: v = pick_between(cfg_model.ok_min, cfg_model.ok_max);
			PICK_EDGE: begin
				case ($urandom_range(5))
					0: base = cfg_model.fault_min;
					1: base = cfg_model.fault_max;
					2: base = cfg_model.ok_min;
					3: base = cfg_model.ok_max;
					4: base = cfg_model.supply_level;
					default: base = cfg_model.ground_level;
				endcase
				v = base + int'($urandom_range(2)) - 1;
				if (v < 0)
					v = 0;
			end
			PICK_SPAN: v = $urandom_range(0, SAMPLE_TOP);
			default: v = $urandom_range(0, RAW_TOP);
		endcase
		return v[wdlm_pkg::RAW_W-1:0];
	endfunction

	task automatic send_sample(input logic [wdlm_pkg::RAW_W-1:0] raw, input logic integ,
			input logic acq, input logic inh);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_sample <= raw;
		integration_mode <= integ;
		acquire_enable <= acq;
		diag_inhibit <= inh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_levels.push_back(predict_tick(raw, integ, acq, inh));
	endtask

	task automatic write_reg(input logic [wdlm_pkg::IDX_W-1:0] idx,
			input logic [wdlm_pkg::DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			wdlm_pkg::REG_FAULT_MAX:
				cfg_model.fault_max = data[wdlm_pkg::SAMPLE_W-1:0];
			wdlm_pkg::REG_FAULT_MIN:
				cfg_model.fault_min = data[wdlm_pkg::SAMPLE_W-1:0];
			wdlm_pkg::REG_OK_MAX:
				cfg_model.ok_max = data[wdlm_pkg::SAMPLE_W-1:0];
			wdlm_pkg::REG_OK_MIN:
				cfg_model.ok_min = data[wdlm_pkg::SAMPLE_W-1:0];
			wdlm_pkg::REG_RISE_LIMIT:
				cfg_model.rise_limit = data[wdlm_pkg::COUNT_W-1:0];
			wdlm_pkg::REG_FALL_LIMIT:
				cfg_model.fall_limit = data[wdlm_pkg::COUNT_W-1:0];
			wdlm_pkg::REG_SUPPLY_LEVEL:
				cfg_model.supply_level = data[wdlm_pkg::SAMPLE_W-1:0];
			wdlm_pkg::REG_GROUND_LEVEL:
				cfg_model.ground_level = data[wdlm_pkg::SAMPLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2)
			@(posedge clk);
	endtask

	// reset register values: window edges, short bands, suspended and inhibited ticks
	task automatic test_directed_edges();
		logic [wdlm_pkg::RAW_W-1:0] edge_samples[14];
		edge_samples = '{16'd0, 16'd65535, 16'd4096, 16'd4097, 16'd999, 16'd1000, 16'd1500,
			16'd1501, 16'd2499, 16'd2500, 16'd3000, 16'd3001, 16'd100, 16'd4000};
		foreach (edge_samples[i])
			send_sample(edge_samples[i], 1'b0, 1'b1, 1'b0);
		send_sample(16'd1200, 1'b1, 1'b1, 1'b0);
		send_sample(16'd1200, 1'b0, 1'b0, 1'b0);
		send_sample(16'd1200, 1'b1, 1'b0, 1'b1);
		send_sample(16'd2700, 1'b0, 1'b1, 1'b1);
		repeat (7)
			send_sample(16'd2700, 1'b0, 1'b1, 1'b0);
		wait_drained();
	endtask

	// long output stall so the block fills and stalls its input
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (30)
			send_sample(pick_sample(pick_kind()), 1'b0, 1'b1, 1'($urandom_range(1)));
		wait_drained();
	endtask

	task automatic test_stream(input int gap_send, input int gap_recv, input int n_items,
			input reg_setting_t setting);
		int         sent;
		int         run_len;
		int         mn;
		pick_kind_t kind;
		logic       integ;
		logic       acq;
		logic       inh;
		wait_drained();
		case (setting)
			SET_LOW: begin
				for (int i = 0; i < NUM_REGS; i++)
					write_reg(i[wdlm_pkg::IDX_W-1:0], '0);
			end
			SET_HIGH: begin
				for (int i = 0; i < NUM_REGS; i++)
					write_reg(i[wdlm_pkg::IDX_W-1:0], '1);
				write_reg(wdlm_pkg::REG_FAULT_MIN, wdlm_pkg::DATA_W'(SAMPLE_TOP));
				write_reg(wdlm_pkg::REG_OK_MIN, wdlm_pkg::DATA_W'(SAMPLE_TOP - 1));
			end
			default: begin
				mn = $urandom_range(0, SAMPLE_TOP);
				write_reg(wdlm_pkg::REG_FAULT_MIN, noisy(mn, wdlm_pkg::SAMPLE_W));
				write_reg(wdlm_pkg::REG_FAULT_MAX, noisy(window_top(mn), wdlm_pkg::SAMPLE_W));
				mn = $urandom_range(0, SAMPLE_TOP);
				write_reg(wdlm_pkg::REG_OK_MIN, noisy(mn, wdlm_pkg::SAMPLE_W));
				write_reg(wdlm_pkg::REG_OK_MAX, noisy(window_top(mn), wdlm_pkg::SAMPLE_W));
				write_reg(wdlm_pkg::REG_RISE_LIMIT, noisy(debounce_pick(), wdlm_pkg::COUNT_W));
				write_reg(wdlm_pkg::REG_FALL_LIMIT, noisy(debounce_pick(), wdlm_pkg::COUNT_W));
				if ($urandom_range(99) < 80)
					write_reg(wdlm_pkg::REG_SUPPLY_LEVEL,
						noisy($urandom_range(3000, SAMPLE_TOP), wdlm_pkg::SAMPLE_W));
				else
					write_reg(wdlm_pkg::REG_SUPPLY_LEVEL,
						noisy($urandom_range(SAMPLE_TOP + 1, REG13_TOP), wdlm_pkg::SAMPLE_W));
				write_reg(wdlm_pkg::REG_GROUND_LEVEL,
					noisy($urandom_range(0, 600), wdlm_pkg::SAMPLE_W));
				write_reg(wdlm_pkg::IDX_W'($urandom_range(NUM_REGS, IDX_TOP)),
					wdlm_pkg::DATA_W'($urandom));
			end
		endcase
		send_gap_pct = gap_send;
		recv_gap_pct = gap_recv;
		sent = 0;
		while (sent < n_items) begin
			kind = pick_kind();
			run_len = $urandom_range(1, 12);
			repeat (run_len) begin
				integ = $urandom_range(99) < 6;
				acq = $urandom_range(99) >= 6;
				inh = $urandom_range(99) < 15;
				send_sample(pick_sample(kind), integ, acq, inh);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= $urandom_range(99) >= recv_gap_pct;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_levels = {clamped_sample, measured_state, filtered_state, short_supply_flag,
				short_ground_flag, invalid_level_flag, monitor_running};
			if (expected_levels.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result with none pending: %s", $time, show_levels(got_levels));
			end else begin
				want_levels = expected_levels.pop_front();
				if (got_levels.sample !== want_levels.sample ||
						got_levels.measured !== want_levels.measured ||
						got_levels.filtered !== want_levels.filtered ||
						got_levels.supply !== want_levels.supply ||
						got_levels.ground !== want_levels.ground ||
						got_levels.invalid !== want_levels.invalid ||
						got_levels.monitor !== want_levels.monitor) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("%0t: mismatch", $time);
						$display("  expected %s", show_levels(want_levels));
						$display("  actual   %s", show_levels(got_levels));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no request moved for %0d cycles", $time, idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		cfg_model = '{wdlm_pkg::RST_FAULT_MAX, wdlm_pkg::RST_FAULT_MIN, wdlm_pkg::RST_OK_MAX,
			wdlm_pkg::RST_OK_MIN, wdlm_pkg::RST_RISE_LIMIT, wdlm_pkg::RST_FALL_LIMIT,
			wdlm_pkg::RST_SUPPLY_LEVEL, wdlm_pkg::RST_GROUND_LEVEL};
		trk = '{sample: '0, measured: 1'b1, default: 1'b0};
		trk_count = '0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);
		test_directed_edges();
		test_backpressure();
		test_stream(26, 55, 90, SET_RANDOM);
		test_stream(26, 55, 90, SET_LOW);
		test_stream(55, 26, 90, SET_RANDOM);
		test_stream(55, 26, 90, SET_HIGH);
		test_stream(0, 0, 90, SET_RANDOM);
		test_stream(0, 0, 90, SET_RANDOM);
		wait_drained();
		repeat (LATENCY * 4)
			@(posedge clk);
		if (expected_levels.size() != 0)
			$display("%0d results never arrived", expected_levels.size());
		if (fail_count == 0 && expected_levels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### window_debounce_level_monitor.f
+incdir+rtl
rtl/wdlm_pkg.sv
rtl/window_debounce_level_monitor.sv
rtl/wdlm_checker.sv
sim/window_debounce_level_monitor_tb.sv
